FILE: hw/rtl/mie_pkg.sv
// ----------------------------------------------------------------------------
// mie_pkg: shared types and constants for the modular inverse block
// Operand widths, sequencer states and the step unit's interface structs.
// ----------------------------------------------------------------------------
package mie_pkg;

  // Operand and field width (datapath intermediates are 32 bits unsigned, operands use 31)
  localparam int unsigned OPW = 31;
  localparam int unsigned CNT_W = $clog2(OPW);

  // Last bit index of one division pass
  localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(OPW - 1);

  // Modulus after reset
  localparam logic [OPW-1:0] MOD_RESET = OPW'(256);

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_TEST = 3'b010,
    S_DIV  = 3'b100
  } state_t;

  // One bit step of division plus modular Horner accumulation
  typedef struct packed {
    logic [OPW-1:0] rem;      // partial remainder
    logic           dbit;     // next dividend bit, MSB first
    logic [OPW-1:0] divisor;  // current r1
    logic [OPW-1:0] acc;      // running (q * t1) mod m
    logic [OPW-1:0] t1;       // current coefficient
    logic [OPW-1:0] modulus;  // m
  } step_in_t;

  typedef struct packed {
    logic [OPW-1:0] rem;
    logic [OPW-1:0] acc;
    logic           qbit;
  } step_out_t;

endpackage

FILE: hw/rtl/mie_step.sv
// ----------------------------------------------------------------------------
// mie_step: one bit step of the shared divide / modular multiply unit
// Restoring division yields quotient bits MSB first; each bit feeds a Horner
// step of (q * t1) mod m, so the quotient is never stored.
// ----------------------------------------------------------------------------
module mie_step (
  input  mie_pkg::step_in_t  si,
  output mie_pkg::step_out_t so
);
  import mie_pkg::*;

  logic [OPW:0] trial;
  logic [OPW:0] div_ext;
  logic         take;
  logic [OPW:0] rem_sub;
  logic [OPW:0] mod_ext;
  logic [OPW:0] dbl;
  logic [OPW:0] s1;
  logic [OPW:0] s2;
  logic [OPW:0] s3;

  // Trial subtract of the divisor from the shifted remainder
  assign trial   = {si.rem, si.dbit};
  assign div_ext = {1'b0, si.divisor};
  assign take    = (trial >= div_ext);
  assign rem_sub = take ? (trial - div_ext) : trial;

  // Double the accumulator, then add t1 when the quotient bit is set
  assign mod_ext = {1'b0, si.modulus};
  assign dbl     = {si.acc, 1'b0};
  assign s1      = (dbl >= mod_ext) ? (dbl - mod_ext) : dbl;
  assign s2      = s1 + (take ? {1'b0, si.t1} : '0);
  assign s3      = (s2 >= mod_ext) ? (s2 - mod_ext) : s2;

  assign so.rem  = rem_sub[OPW-1:0];
  assign so.acc  = s3[OPW-1:0];
  assign so.qbit = take;

endmodule

FILE: hw/rtl/modular_inverse_euclid.sv
// ----------------------------------------------------------------------------
// modular_inverse_euclid: modular inverse by the extended Euclidean algorithm
// Reports gcd(value, modulus), an inverse-exists flag and the inverse.
// ----------------------------------------------------------------------------
//  channel | ports                                        | handshake
//  --------+----------------------------------------------+-------------------
//  input   | in_value                                     | start & !busy
//  result  | out_inverse, out_has_inverse, out_gcd        | out_valid strobe
//  config  | cfg_wdata (modulus)                          | cfg_we
//
// Each Euclid step is a visit to the test state plus one division pass through
// the shared step unit (quotient bit and modular multiply-accumulate per
// cycle); the last pass cycle retires the step. A final visit to the test
// state ends the run, and the result strobes in the cycle after it.
// Reset (rst_n low, synchronous) returns to idle and sets modulus to 256.
// busy is high from acceptance until the result strobe; the receiver cannot
// stall, so each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module modular_inverse_euclid (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [mie_pkg::OPW-1:0]  in_value,
  output logic                     out_valid,
  output logic [mie_pkg::OPW-1:0]  out_inverse,
  output logic                     out_has_inverse,
  output logic [mie_pkg::OPW-1:0]  out_gcd,
  input  logic                     cfg_we,
  input  logic [mie_pkg::OPW-1:0]  cfg_wdata
);
  import mie_pkg::*;

  state_t           state_r, state_nxt;
  logic [OPW-1:0]   modulus_r;
  logic [OPW-1:0]   r0_r, r0_nxt;
  logic [OPW-1:0]   r1_r, r1_nxt;
  logic [OPW-1:0]   t0_r, t0_nxt;
  logic [OPW-1:0]   t1_r, t1_nxt;
  logic [OPW-1:0]   rem_r, rem_nxt;
  logic [OPW-1:0]   dvd_r, dvd_nxt;
  logic [OPW-1:0]   acc_r, acc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [OPW-1:0]   out_inverse_r, out_inverse_nxt;
  logic             out_has_r, out_has_nxt;
  logic [OPW-1:0]   out_gcd_r, out_gcd_nxt;

  logic             m_ge2;
  logic             has;
  logic [OPW:0]     diff;
  logic [OPW-1:0]   t2;
  step_in_t         si;
  step_out_t        so;

  assign m_ge2 = |modulus_r[OPW-1:1];

  // Shared step unit
  assign si.rem     = rem_r;
  assign si.dbit    = dvd_r[OPW-1];
  assign si.divisor = r1_r;
  assign si.acc     = acc_r;
  assign si.t1      = t1_r;
  assign si.modulus = modulus_r;

  mie_step u_step (
    .si (si),
    .so (so)
  );

  // Next coefficient: t0 - (q * t1 mod m), wrapped into 0..m-1
  assign diff = {1'b0, t0_r} - {1'b0, acc_r};
  assign t2   = diff[OPW] ? (diff[OPW-1:0] + modulus_r) : diff[OPW-1:0];

  assign has  = (r0_r == OPW'(1)) && (modulus_r != '0);

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    r0_nxt          = r0_r;
    r1_nxt          = r1_r;
    t0_nxt          = t0_r;
    t1_nxt          = t1_r;
    rem_nxt         = rem_r;
    dvd_nxt         = dvd_r;
    acc_nxt         = acc_r;
    cnt_nxt         = cnt_r;
    out_valid_nxt   = 1'b0;
    out_inverse_nxt = out_inverse_r;
    out_has_nxt     = out_has_r;
    out_gcd_nxt     = out_gcd_r;
    unique case (state_r)
      S_IDLE: begin
        // Load the remainder and coefficient pairs
        if (start) begin
          r0_nxt    = modulus_r;
          r1_nxt    = in_value;
          t0_nxt    = '0;
          t1_nxt    = m_ge2 ? OPW'(1) : '0;
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        if (r1_r == '0) begin
          // Finish: report gcd and the coefficient
          out_valid_nxt   = 1'b1;
          out_gcd_nxt     = r0_r;
          out_has_nxt     = has;
          out_inverse_nxt = has ? t0_r : '0;
          state_nxt       = S_IDLE;
        end else begin
          // Start a division pass of r0 by r1
          rem_nxt   = '0;
          dvd_nxt   = r0_r;
          acc_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // Advance one quotient bit
        rem_nxt = so.rem;
        acc_nxt = so.acc;
        dvd_nxt = {dvd_r[OPW-2:0], 1'b0};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == STEP_LAST) begin
          // Retire the Euclid step using this cycle's results
          r0_nxt    = r1_r;
          r1_nxt    = so.rem;
          t0_nxt    = t1_r;
          state_nxt = S_TEST;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The retire step needs the final acc, so compute t1 from the unit output
  logic [OPW:0]   diff_last;
  logic [OPW-1:0] t2_last;
  assign diff_last = {1'b0, t0_r} - {1'b0, so.acc};
  assign t2_last   = diff_last[OPW] ? (diff_last[OPW-1:0] + modulus_r)
                                    : diff_last[OPW-1:0];

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      modulus_r   <= MOD_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        modulus_r <= cfg_wdata;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    r0_r          <= r0_nxt;
    r1_r          <= r1_nxt;
    t0_r          <= t0_nxt;
    if (state_r == S_DIV && cnt_r == STEP_LAST) begin
      t1_r <= m_ge2 ? t2_last : '0;
    end else begin
      t1_r <= t1_nxt;
    end
    rem_r         <= rem_nxt;
    dvd_r         <= dvd_nxt;
    acc_r         <= acc_nxt;
    cnt_r         <= cnt_nxt;
    out_inverse_r <= out_inverse_nxt;
    out_has_r     <= out_has_nxt;
    out_gcd_r     <= out_gcd_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_inverse     = out_inverse_r;
  assign out_has_inverse = out_has_r;
  assign out_gcd         = out_gcd_r;

  // Difference against the registered accumulator, kept for checking
  logic t2_in_range;
  assign t2_in_range = !m_ge2 || (t2 < modulus_r);

  // An inverse is only reported with gcd one
  a_has_gcd_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_has_inverse || out_gcd == OPW'(1)))
    else $error("inverse flagged without unit gcd");

  // Partial remainder stays below the divisor during a pass
  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < r1_r))
    else $error("partial remainder not reduced");

  // Accumulator and coefficients stay reduced modulo m
  a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && m_ge2) |-> (acc_r < modulus_r && t2_in_range))
    else $error("modular accumulator out of range");

  a_coef_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TEST && m_ge2) |-> (t1_r < modulus_r && t0_r < modulus_r))
    else $error("coefficient out of range");

  // An accepted item makes the block busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // Result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

endmodule

FILE: sim/inverse_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// inverse_checker: result checker for modular_inverse_euclid
// Follows the modulus register, predicts gcd, inverse flag and inverse for
// every accepted item, and compares each result strobe with the oldest
// prediction still outstanding.
// ----------------------------------------------------------------------------
module inverse_checker (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     busy,
  input  logic [mie_pkg::OPW-1:0]  in_value,
  input  logic                     out_valid,
  input  logic [mie_pkg::OPW-1:0]  out_inverse,
  input  logic                     out_has_inverse,
  input  logic [mie_pkg::OPW-1:0]  out_gcd,
  input  logic                     cfg_we,
  input  logic [mie_pkg::OPW-1:0]  cfg_wdata,
  output int                       fail_count,
  output int                       outstanding
);

  localparam int unsigned W = mie_pkg::OPW;

  typedef struct packed {
    logic [W-1:0] inverse;
    logic         has_inverse;
    logic [W-1:0] gcd;
  } inverse_result_t;

  logic [W-1:0]    modulus_q = mie_pkg::MOD_RESET;
  inverse_result_t inverse_q[$];

  // Extended Euclid on the remainder sequence (modulus, value, ...), with the
  // coefficient of value kept reduced into 0..modulus-1 after every step
  function automatic inverse_result_t euclid_inverse(input logic [W-1:0] value,
                                                     input logic [W-1:0] modulus);
    logic [63:0]     m;
    logic [63:0]     r0;
    logic [63:0]     r1;
    logic [63:0]     r2;
    logic [63:0]     q;
    logic [63:0]     t0;
    logic [63:0]     t1;
    logic [63:0]     t2;
    logic [63:0]     prod;
    inverse_result_t res;
    m  = 64'(modulus);
    r0 = m;
    r1 = 64'(value);
    t0 = '0;
    t1 = (m >= 64'd2) ? 64'd1 : 64'd0;
    while (r1 != 64'd0) begin
      q  = r0 / r1;
      r2 = r0 % r1;
      t2 = '0;
      // no reduction is possible for modulus zero or one
      if (m >= 64'd2) begin
        prod = ((q % m) * t1) % m;
        t2   = (t0 + m - prod) % m;
      end
      r0 = r1;
      r1 = r2;
      t0 = t1;
      t1 = t2;
    end
    res.has_inverse = (r0 == 64'd1) && (m != 64'd0);
    res.inverse     = (res.has_inverse && m >= 64'd2) ? W'(t0) : '0;
    res.gcd         = W'(r0);
    return res;
  endfunction

  always @(posedge clk) begin
    inverse_result_t want;
    if (!rst_n) begin
      inverse_q.delete();
      modulus_q   <= mie_pkg::MOD_RESET;
      outstanding <= 0;
      fail_count  = 0;
    end else begin
      // retire the result before taking a new item, so a same-edge accept
      // can never be matched against its own strobe
      if (out_valid) begin
        if (inverse_q.size() == 0) begin
          $error("result strobe with no item outstanding");
          fail_count++;
        end else begin
          want = inverse_q.pop_front();
          if (out_inverse !== want.inverse) begin
            $error("inverse: expected %0d, got %0d", want.inverse, out_inverse);
            fail_count++;
          end
          if (out_has_inverse !== want.has_inverse) begin
            $error("has_inverse: expected %0d, got %0d", want.has_inverse,
                   out_has_inverse);
            fail_count++;
          end
          if (out_gcd !== want.gcd) begin
            $error("gcd: expected %0d, got %0d", want.gcd, out_gcd);
            fail_count++;
          end
        end
      end
      // predict from the modulus in force at acceptance
      if (start && !busy) begin
        inverse_q.insert(inverse_q.size(), euclid_inverse(in_value, modulus_q));
      end
      if (cfg_we) begin
        modulus_q <= cfg_wdata;
      end
      outstanding <= inverse_q.size();
    end
  end

endmodule

FILE: sim/modular_inverse_euclid_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modular_inverse_euclid_tb: testbench for the modular inverse block
// Runs directed corner items under several moduli (reset value, largest,
// two, one and zero), then random items over a series of modulus settings,
// with random gaps on the input side. Results are checked by inverse_checker.
// ----------------------------------------------------------------------------
module modular_inverse_euclid_tb;

  localparam int unsigned W            = mie_pkg::OPW;
  localparam logic [W-1:0] MOD_MAX     = '1;
  localparam int          CYCLE_LIMIT  = 3_000_000;
  localparam int          DRAIN_CYCLES = 1600;
  localparam int          NUM_PHASES   = 9;
  localparam int          QUIET_PHASE  = 6;
  localparam int          PHASE_ITEMS[NUM_PHASES] = '{60, 50, 50, 50, 10, 10, 60, 50, 60};

  logic         clk       = 1'b0;
  logic         rst_n     = 1'b0;
  logic         start     = 1'b0;
  logic [W-1:0] in_value  = '0;
  logic         cfg_we    = 1'b0;
  logic [W-1:0] cfg_wdata = '0;
  logic         busy;
  logic         out_valid;
  logic [W-1:0] out_inverse;
  logic         out_has_inverse;
  logic [W-1:0] out_gcd;

  int           fail_count;
  int           outstanding;
  int           cycle_count = 0;
  logic [W-1:0] modulus_now = mie_pkg::MOD_RESET;
  bit           idle_on     = 1'b1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  modular_inverse_euclid u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_inverse     (out_inverse),
    .out_has_inverse (out_has_inverse),
    .out_gcd         (out_gcd),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  inverse_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_inverse     (out_inverse),
    .out_has_inverse (out_has_inverse),
    .out_gcd         (out_gcd),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .outstanding     (outstanding)
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("modular_inverse_euclid verification failed");
      $finish;
    end
  end

  // Offer one item and hold it until accepted, then idle now and then
  task automatic send_value(input logic [W-1:0] value);
    in_value <= value;
    start    <= 1'b1;
    do @(posedge clk); while (busy);
    if (idle_on && $urandom_range(99) < 15) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 60)) @(posedge clk);
    end
  endtask

  // Drop start and wait until every outstanding result has come back
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_modulus(input logic [W-1:0] m);
    cfg_wdata   <= m;
    cfg_we      <= 1'b1;
    @(posedge clk);
    cfg_we      <= 1'b0;
    modulus_now = m;
  endtask

  task automatic directed_phase(input bit do_write, input logic [W-1:0] m,
                                input logic [W-1:0] values[$]);
    drain_results();
    if (do_write) begin
      write_modulus(m);
    end
    foreach (values[i]) begin
      send_value(values[i]);
    end
  endtask

  // Mostly residues, plus full-width values, tiny values and values near m
  function automatic logic [W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 60 && modulus_now >= W'(2)) begin
      return W'($urandom_range(0, modulus_now - W'(1)));
    end else if (sel < 85) begin
      return W'($urandom);
    end else if (sel < 95) begin
      return W'($urandom_range(0, 20));
    end
    case ($urandom_range(3))
      0:       return modulus_now;
      1:       return modulus_now - W'(1);
      2:       return modulus_now + W'(1);
      default: return MOD_MAX;
    endcase
  endfunction

  function automatic logic [W-1:0] pick_modulus(input int phase);
    case (phase)
      0, 6:    return W'($urandom_range(2, 32'h7FFF_FFFF));
      1:       return MOD_MAX;
      2, 8:    return W'($urandom_range(2, 1000));
      3:       return W'(32'd1 << $urandom_range(1, 30));
      4:       return W'(1);
      5:       return W'(0);
      default: return mie_pkg::MOD_RESET;
    endcase
  endfunction

  initial begin
    logic [W-1:0] at_reset[$];
    logic [W-1:0] at_max[$];
    logic [W-1:0] at_two[$];
    logic [W-1:0] at_one[$];
    logic [W-1:0] at_zero[$];
    at_reset = '{W'(0), W'(1), W'(2), W'(3), W'(255), W'(256), W'(257), W'(511),
                 MOD_MAX, W'(32'h2AAA_AAAA), W'(32'h5555_5555)};
    at_max   = '{W'(0), W'(1), MOD_MAX, MOD_MAX - W'(1), W'(1234567891)};
    at_two   = '{W'(0), W'(1), W'(3), MOD_MAX};
    at_one   = '{W'(0), W'(5)};
    at_zero  = '{W'(0), W'(7)};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Corner items: reset modulus first, then the extremes of the register
    directed_phase(1'b0, mie_pkg::MOD_RESET, at_reset);
    directed_phase(1'b1, MOD_MAX, at_max);
    directed_phase(1'b1, W'(2), at_two);
    directed_phase(1'b1, W'(1), at_one);
    directed_phase(1'b1, W'(0), at_zero);

    // Random items, one modulus per phase; one phase runs without gaps
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      write_modulus(pick_modulus(p));
      idle_on = (p != QUIET_PHASE);
      repeat (PHASE_ITEMS[p]) send_value(pick_value());
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("modular_inverse_euclid verification clean");
    end else begin
      $display("modular_inverse_euclid verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/mie_pkg.sv
hw/rtl/mie_step.sv
hw/rtl/modular_inverse_euclid.sv
sim/inverse_checker.sv
sim/modular_inverse_euclid_tb.sv
